[hdl/bfz_pkg.sv]
// bfz_pkg: shared types, constants and register codes for the 3x3 box filter
// used by the channel interfaces, the line store ram and the top level
// no dependencies
package bfz_pkg;

	localparam int unsigned PIX_W        = 8;
	localparam int unsigned LINE_W_W     = 12;
	localparam int unsigned FRAME_H_W    = 13;
	localparam int unsigned ROW_W        = 13;
	localparam int unsigned MAX_WIDTH_DEF = 2048;

	localparam logic [LINE_W_W-1:0]  LINE_WIDTH_RST   = 12'd640;
	localparam logic [FRAME_H_W-1:0] FRAME_HEIGHT_RST = 13'd480;
	localparam logic [FRAME_H_W-1:0] HEIGHT_LIMIT     = 13'd4096;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// floor(x / 9) = (x * 3641) >> 15 for x below 4096
	localparam int unsigned SUM_W      = 12;
	localparam int unsigned DIV9_MUL_W = 12;
	localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 12'd3641;
	localparam int unsigned DIV9_SHIFT = 15;

	localparam int unsigned RAM_WIDTH_DEF = 16;
	localparam int unsigned RAM_DEPTH_DEF = 2048;

	typedef logic [PIX_W-1:0] pixel_t;

endpackage

[hdl/bfz_intf.sv]
// bfz channel interfaces: pixel input, mean output and register write
// each carries valid, ready and the word payload
// depends on bfz_pkg
interface bfz_pix_if;
	import bfz_pkg::*;
	logic   valid;
	logic   ready;
	logic   cmd;
	pixel_t pixel;
	modport source (output valid, output cmd, output pixel, input ready);
	modport sink (input valid, input cmd, input pixel, output ready);
endinterface

interface bfz_mean_if;
	import bfz_pkg::*;
	logic   valid;
	logic   ready;
	pixel_t mean_pixel;
	logic   frame_last;
	modport source (output valid, output mean_pixel, output frame_last, input ready);
	modport sink (input valid, input mean_pixel, input frame_last, output ready);
endinterface

interface bfz_cfg_if;
	import bfz_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/bfz_ram.sv]
// bfz_ram: generic simple dual port ram, one write and one registered read port
// depends on bfz_pkg for default sizes
module bfz_ram #(
	parameter int unsigned WIDTH = bfz_pkg::RAM_WIDTH_DEF,
	parameter int unsigned DEPTH = bfz_pkg::RAM_DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[hdl/box_filter_3x3_zero_pad_top.sv]
// box_filter_3x3_zero_pad_top: streaming 3x3 mean filter with zero padding
// depends on bfz_pkg, bfz_intf (channel interfaces) and bfz_ram (line stores)
//
// channel   dir  payload                    role
// pixels    in   cmd, pixel                 raster pixels, then flush words
// results   out  mean_pixel, frame_last     one mean per frame pixel
// cfg       in   index, data                line_width, frame_height
//
// one word per clock sustained while results are taken; a word passes the line store
// read stage and then the output register
// the line store read port and the window add/multiply set the cycle time
// arst_n clears counters, window and valid flags; registers go to 640x480
// a stalled result holds the read stage, which then drops pixels.ready
// line stores need no clearing: they are only read where written this frame
module box_filter_3x3_zero_pad_top #(
	parameter int unsigned MAX_WIDTH = bfz_pkg::MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bfz_pix_if.sink     pixels,
	bfz_mean_if.source  results,
	bfz_cfg_if.sink     cfg
);
	import bfz_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int LW = (WW > LINE_W_W) ? WW : LINE_W_W;
	localparam logic [LW-1:0] MAX_W_L = LW'(MAX_WIDTH);

	typedef struct packed {
		logic [CW-1:0] addr;
		logic          col0;
		logic          top_en;
		logic          mid_en;
		pixel_t        bot;
		logic          res_valid;
		logic          res_last;
	} stage_t;

	logic [LINE_W_W-1:0]  line_width_q;
	logic [FRAME_H_W-1:0] frame_height_q;
	logic [WW-1:0]        w_eff;
	logic [ROW_W-1:0]     h_eff;
	logic [ROW_W-1:0]     h_plus1;
	logic [LW-1:0]        lw_ext;

	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    c0;
	logic [ROW_W-1:0] r0;
	logic             wrap;
	logic             last_pos;
	logic [WW-1:0]    c_inc;
	stage_t           st_in;

	logic             accept;
	logic             cfg_wr;
	logic             s1_valid_q;
	stage_t           st_s1;
	logic             byp_s1;
	logic [2*PIX_W-1:0] byp_data_s1;
	logic             s1_fire;
	logic             out_free;

	logic [2*PIX_W-1:0] ram_rdata;
	logic [2*PIX_W-1:0] line_rd;
	logic [2*PIX_W-1:0] wdata;
	pixel_t             top;
	pixel_t             mid;
	pixel_t             win_q [6];
	logic [SUM_W-1:0]   sum;
	logic [SUM_W+DIV9_MUL_W-1:0] prod;

	logic   out_valid_q;
	pixel_t mean_q;
	logic   last_q;

	// register writes
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= LINE_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_wr) begin
			if (cfg.index == REG_LINE_WIDTH) begin
				line_width_q <= cfg.data[LINE_W_W-1:0];
			end else if (cfg.index == REG_FRAME_HEIGHT) begin
				frame_height_q <= cfg.data[FRAME_H_W-1:0];
			end
		end
	end

	// clamped frame size
	always_comb begin
		lw_ext = LW'(line_width_q);
		if (lw_ext == '0) begin
			w_eff = WW'(1);
		end else if (lw_ext > MAX_W_L) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(lw_ext);
		end
		if (frame_height_q == '0) begin
			h_eff = ROW_W'(1);
		end else if (frame_height_q > HEIGHT_LIMIT) begin
			h_eff = ROW_W'(HEIGHT_LIMIT);
		end else begin
			h_eff = ROW_W'(frame_height_q);
		end
		h_plus1 = h_eff + ROW_W'(1);
	end

	// position of the incoming word and its flags
	assign out_free     = !out_valid_q || results.ready;
	assign s1_fire      = s1_valid_q && out_free;
	assign pixels.ready = !s1_valid_q || s1_fire;
	assign accept       = pixels.valid && pixels.ready;

	always_comb begin
		wrap     = (WW'(col_q) >= w_eff) || (row_q > h_plus1);
		c0       = wrap ? '0 : col_q;
		r0       = wrap ? '0 : row_q;
		last_pos = (c0 == '0) && (r0 == h_plus1);
		c_inc    = WW'(c0) + WW'(1);

		st_in.addr   = c0;
		st_in.col0   = (c0 == '0);
		st_in.top_en = (r0 >= ROW_W'(2));
		st_in.mid_en = (r0 != '0);
		st_in.bot    = ((pixels.cmd == CMD_PIXEL) && (r0 < h_eff)) ? pixels.pixel : '0;
		if (c0 == '0) begin
			st_in.res_valid = (r0 >= ROW_W'(2)) && (r0 <= h_plus1);
		end else begin
			st_in.res_valid = (r0 != '0) && (r0 <= h_eff);
		end
		st_in.res_last = last_pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr && (cfg.index == REG_LINE_WIDTH ||
				cfg.index == REG_FRAME_HEIGHT)) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_pos) begin
				col_q <= '0;
				row_q <= '0;
			end else if (c_inc >= w_eff) begin
				col_q <= '0;
				row_q <= r0 + ROW_W'(1);
			end else begin
				col_q <= CW'(c_inc);
				row_q <= r0;
			end
		end
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			byp_s1     <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
			byp_s1     <= s1_fire && (st_s1.addr == c0);
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			st_s1       <= st_in;
			byp_data_s1 <= wdata;
		end
	end

	// line stores: upper byte two rows above, lower byte one row above
	bfz_ram #(
		.WIDTH (2 * PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (s1_fire),
		.waddr (st_s1.addr),
		.wdata (wdata),
		.re    (accept),
		.raddr (c0),
		.rdata (ram_rdata)
	);

	always_comb begin
		line_rd = byp_s1 ? byp_data_s1 : ram_rdata;
		top     = st_s1.top_en ? line_rd[2*PIX_W-1:PIX_W] : '0;
		mid     = st_s1.mid_en ? line_rd[PIX_W-1:0] : '0;
		wdata   = {mid, st_s1.bot};
		sum     = SUM_W'(win_q[0]) + SUM_W'(win_q[1]) + SUM_W'(win_q[2])
			+ SUM_W'(win_q[3]) + SUM_W'(win_q[4]) + SUM_W'(win_q[5]);
		if (!st_s1.col0) begin
			sum = sum + SUM_W'(top) + SUM_W'(mid) + SUM_W'(st_s1.bot);
		end
		prod = (SUM_W + DIV9_MUL_W)'(sum) * (SUM_W + DIV9_MUL_W)'(DIV9_MUL);
	end

	// window: two older columns, oldest first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_fire) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i] <= st_s1.col0 ? '0 : win_q[i+3];
			end
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= st_s1.bot;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && st_s1.res_valid) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && st_s1.res_valid) begin
			mean_q <= PIX_W'(prod >> DIV9_SHIFT);
			last_q <= st_s1.res_last;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.mean_pixel = mean_q;
	assign results.frame_last = last_q;

	// checks
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(WW'(col_q) < w_eff))
		else $error("column counter beyond line width");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q <= h_plus1))
		else $error("row counter beyond frame end");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_fire) |=> (s1_valid_q && $stable(st_s1.addr)))
		else $error("stalled read stage lost its word");

endmodule
